// File: hdl/tcc_pkg.sv
// Shared constants, types and the arctangent table for the tilt-compensated compass.
package tcc_pkg;

   localparam int CordicSteps = 16;
   localparam int TabLen      = 24;
   localparam int StepW       = 5;
   localparam int DataW       = 52;
   localparam int AngW        = 33;
   localparam int TrigW       = 33;
   localparam int SqrtSteps   = 32;
   localparam logic signed [DataW-1:0] GainQ30 = DataW'(652032875);
   localparam logic signed [15:0] QuarterTurn = 16'sd16384;

   typedef struct packed {
      logic                    start;
      logic                    vector;
      logic signed [DataW-1:0] x;
      logic signed [DataW-1:0] y;
      logic [15:0]             angle;
   } cordic_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [15:0]             angle;
      logic signed [TrigW-1:0] cos_q30;
      logic signed [TrigW-1:0] sin_q30;
   } cordic_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_ROLL_GO  = 17'h00002,
      S_ROLL     = 17'h00004,
      S_GG       = 17'h00008,
      S_AA       = 17'h00010,
      S_SQRT_GO  = 17'h00020,
      S_SQRT     = 17'h00040,
      S_PITCH_GO = 17'h00080,
      S_PITCH    = 17'h00100,
      S_SCR_GO   = 17'h00200,
      S_SCR      = 17'h00400,
      S_SCP_GO   = 17'h00800,
      S_SCP      = 17'h01000,
      S_MUL      = 17'h02000,
      S_YAW_GO   = 17'h04000,
      S_YAW      = 17'h08000,
      S_DONE     = 17'h10000
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [StepW-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/tcc_ifs.sv
// Valid/ready channel interfaces for sample, result and register write transactions.
interface tcc_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] acc_x;
   logic signed [15:0] acc_y;
   logic signed [15:0] acc_z;
   logic signed [15:0] mag_x;
   logic signed [15:0] mag_y;
   logic signed [15:0] mag_z;
   modport source (output valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, input ready);
   modport sink (input valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, output ready);
endinterface

interface tcc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic              tilt_held;
   logic              pitch_clamped;
   logic              heading_void;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, tilt_held,
                   pitch_clamped, heading_void, input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_angle, tilt_held,
                 pitch_clamped, heading_void, output ready);
endinterface

interface tcc_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] gravity_counts;
   modport source (output valid, gravity_counts, input ready);
   modport sink (input valid, gravity_counts, output ready);
endinterface

// File: hdl/tcc_cordic.sv
// Shared CORDIC unit, one micro-rotation per clock, vectoring or rotation mode.
module tcc_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  tcc_pkg::cordic_cmd_type cmd,
   output tcc_pkg::cordic_rsp_type rsp
);

   logic signed [tcc_pkg::DataW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [tcc_pkg::AngW-1:0]  z_ff, z_in;
   logic [tcc_pkg::StepW-1:0]        step_ff;
   logic                             busy_ff, done_ff, vec_ff, flip_ff;
   logic signed [tcc_pkg::DataW-1:0] xs, ys;
   logic signed [tcc_pkg::AngW-1:0]  tab;
   logic                             up;
   logic                             flip_in;
   logic [15:0]                      th;
   logic [31:0]                      rounded;

   assign xs  = x_ff >>> step_ff;
   assign ys  = y_ff >>> step_ff;
   assign tab = tcc_pkg::AngW'(tcc_pkg::atan_entry(step_ff));
   assign up  = vec_ff ? y_ff[tcc_pkg::DataW-1] : !z_ff[tcc_pkg::AngW-1];

   always_comb begin
      flip_in = (cmd.angle[15:14] == 2'b01) || (cmd.angle[15:14] == 2'b10);
      th      = flip_in ? (cmd.angle ^ 16'h8000) : cmd.angle;
      if (cmd.start) begin
         if (cmd.vector) begin
            if (cmd.x < 0) begin
               x_in = -cmd.x;
               y_in = -cmd.y;
               z_in = tcc_pkg::AngW'(33'h080000000);
            end else begin
               x_in = cmd.x;
               y_in = cmd.y;
               z_in = '0;
            end
         end else begin
            x_in = tcc_pkg::GainQ30;
            y_in = '0;
            z_in = {th[15], th, 16'h0000};
         end
      end else if (up) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - tab;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + tab;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == tcc_pkg::StepW'(tcc_pkg::CordicSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start || busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (cmd.start) begin
         vec_ff  <= cmd.vector;
         flip_ff <= cmd.vector ? 1'b0 : flip_in;
      end
   end

   assign rounded     = z_ff[31:0] + 32'h0000_8000;
   assign rsp.done    = done_ff;
   assign rsp.angle   = rounded[31:16];
   assign rsp.cos_q30 = flip_ff ? tcc_pkg::TrigW'(-x_ff) : tcc_pkg::TrigW'(x_ff);
   assign rsp.sin_q30 = flip_ff ? tcc_pkg::TrigW'(-y_ff) : tcc_pkg::TrigW'(y_ff);

endmodule

// File: hdl/tcc_sqrt.sv
// Iterative integer square root, two radicand bits per clock.
module tcc_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  tcc_pkg::sqrt_cmd_type cmd,
   output tcc_pkg::sqrt_rsp_type rsp
);

   logic [63:0] v_ff, r_ff, bit_val, trial;
   logic [4:0]  k_ff;
   logic        busy_ff, done_ff;

   assign bit_val = 64'h4000_0000_0000_0000 >> {k_ff, 1'b0};
   assign trial   = r_ff + bit_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (busy_ff) begin
            if (k_ff == 5'(tcc_pkg::SqrtSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         v_ff <= cmd.radicand;
         r_ff <= '0;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_val;
         end else begin
            r_ff <= r_ff >> 1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = r_ff[31:0];

endmodule

// File: hdl/tilt_compensated_compass_core.sv
// Tilt-compensated compass: roll, pitch and heading from one accelerometer and
// magnetometer sample, in 16-bit binary angle units (32768 = pi). The time is set
// by the shared 16-step CORDIC unit and a 32-step square root. The steps run in this
// order: roll pass, square root, pitch pass, two sine/cosine passes, seven products
// on one 33x33 multiplier, heading pass. A sample with zero acc_z skips the roll,
// square root and pitch steps. A clamped pitch skips the square root and pitch
// steps. A zero acc_x with a zero root skips the pitch pass. A zero horizontal
// field skips the heading pass. The input is ready only while the block is idle.
// The result sits in an output register; while a stalled result waits, the next
// result is held in the done state until the output is free.
module tilt_compensated_compass_core (
   input  logic clock,
   input  logic reset,
   tcc_req_if.sink   req_bus,
   tcc_rsp_if.source rsp_bus,
   tcc_csr_if.sink   csr_bus
);

   tcc_pkg::state_type state_ff, state_in;
   tcc_pkg::cordic_cmd_type cor_cmd;
   tcc_pkg::cordic_rsp_type cor_rsp;
   tcc_pkg::sqrt_cmd_type   sq_cmd;
   tcc_pkg::sqrt_rsp_type   sq_rsp;

   logic [14:0] gravity_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, mx_ff, my_ff, mz_ff;
   logic [15:0] roll_ff, pitch_ff, last_roll_ff, last_pitch_ff;
   logic held_ff, clamped_ff;
   logic signed [tcc_pkg::TrigW-1:0] cr_ff, sr_ff, cp_ff, sp_ff, t1_ff, t2_ff;
   logic signed [tcc_pkg::DataW-1:0] xh_ff, yh_ff;
   logic [29:0] gg_ff;
   logic [29:0] diff;
   logic [2:0]  mstep_ff;
   logic signed [tcc_pkg::TrigW-1:0] mul_a, mul_b;
   logic signed [2*tcc_pkg::TrigW-1:0] mul_ff;
   logic [16:0] abs_ax;
   logic        pitch_zero, yaw_zero, out_free;

   logic        rsp_valid_ff;
   logic [15:0] rsp_roll_ff, rsp_pitch_ff, rsp_yaw_ff;
   logic        rsp_held_ff, rsp_clamped_ff, rsp_void_ff;

   tcc_cordic u_cordic (.clock(clock), .reset(reset), .cmd(cor_cmd), .rsp(cor_rsp));
   tcc_sqrt   u_sqrt   (.clock(clock), .reset(reset), .cmd(sq_cmd), .rsp(sq_rsp));

   assign req_bus.ready = (state_ff == tcc_pkg::S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign abs_ax     = ax_ff[15] ? 17'(-17'(ax_ff)) : 17'(ax_ff);
   assign pitch_zero = (ax_ff == 16'sd0) && (sq_rsp.root == 32'd0);
   assign yaw_zero   = (xh_ff == '0) && (yh_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign diff       = 30'(gg_ff - 30'(mul_ff));

   always_comb begin
      cor_cmd.start  = 1'b0;
      cor_cmd.vector = 1'b1;
      cor_cmd.x      = '0;
      cor_cmd.y      = '0;
      cor_cmd.angle  = '0;
      unique case (state_ff)
         tcc_pkg::S_ROLL_GO: begin
            cor_cmd.start = 1'b1;
            cor_cmd.x     = -(tcc_pkg::DataW'(az_ff) <<< 20);
            cor_cmd.y     = tcc_pkg::DataW'(ay_ff) <<< 20;
         end
         tcc_pkg::S_PITCH_GO: begin
            cor_cmd.start = !pitch_zero;
            cor_cmd.x     = tcc_pkg::DataW'(sq_rsp.root);
            cor_cmd.y     = tcc_pkg::DataW'(ax_ff) <<< 16;
         end
         tcc_pkg::S_SCR_GO: begin
            cor_cmd.start  = 1'b1;
            cor_cmd.vector = 1'b0;
            cor_cmd.angle  = roll_ff;
         end
         tcc_pkg::S_SCP_GO: begin
            cor_cmd.start  = 1'b1;
            cor_cmd.vector = 1'b0;
            cor_cmd.angle  = pitch_ff;
         end
         tcc_pkg::S_YAW_GO: begin
            cor_cmd.start = !yaw_zero;
            cor_cmd.x     = xh_ff;
            cor_cmd.y     = yh_ff;
         end
         default: begin
            cor_cmd.start = 1'b0;
         end
      endcase
      sq_cmd.start    = (state_ff == tcc_pkg::S_SQRT_GO);
      sq_cmd.radicand = {2'b00, diff, 32'h0};
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         tcc_pkg::S_GG: begin
            mul_a = tcc_pkg::TrigW'(gravity_ff);
            mul_b = tcc_pkg::TrigW'(gravity_ff);
         end
         tcc_pkg::S_AA: begin
            mul_a = tcc_pkg::TrigW'(ax_ff);
            mul_b = tcc_pkg::TrigW'(ax_ff);
         end
         tcc_pkg::S_MUL: begin
            unique case (mstep_ff)
               3'd0: begin mul_a = sr_ff; mul_b = sp_ff; end
               3'd1: begin mul_a = cr_ff; mul_b = sp_ff; end
               3'd2: begin mul_a = tcc_pkg::TrigW'(mx_ff); mul_b = cp_ff; end
               3'd3: begin mul_a = tcc_pkg::TrigW'(my_ff); mul_b = t1_ff; end
               3'd4: begin mul_a = tcc_pkg::TrigW'(mz_ff); mul_b = t2_ff; end
               3'd5: begin mul_a = tcc_pkg::TrigW'(mz_ff); mul_b = sr_ff; end
               3'd6: begin mul_a = tcc_pkg::TrigW'(my_ff); mul_b = cr_ff; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcc_pkg::S_IDLE:
            if (req_bus.valid) begin
               state_in = (req_bus.acc_z == 16'sd0) ? tcc_pkg::S_SCR_GO : tcc_pkg::S_ROLL_GO;
            end
         tcc_pkg::S_ROLL_GO:  state_in = tcc_pkg::S_ROLL;
         tcc_pkg::S_ROLL:
            if (cor_rsp.done) begin
               state_in = (abs_ax > 17'(gravity_ff)) ? tcc_pkg::S_SCR_GO : tcc_pkg::S_GG;
            end
         tcc_pkg::S_GG:       state_in = tcc_pkg::S_AA;
         tcc_pkg::S_AA:       state_in = tcc_pkg::S_SQRT_GO;
         tcc_pkg::S_SQRT_GO:  state_in = tcc_pkg::S_SQRT;
         tcc_pkg::S_SQRT:     if (sq_rsp.done) state_in = tcc_pkg::S_PITCH_GO;
         tcc_pkg::S_PITCH_GO: state_in = pitch_zero ? tcc_pkg::S_SCR_GO : tcc_pkg::S_PITCH;
         tcc_pkg::S_PITCH:    if (cor_rsp.done) state_in = tcc_pkg::S_SCR_GO;
         tcc_pkg::S_SCR_GO:   state_in = tcc_pkg::S_SCR;
         tcc_pkg::S_SCR:      if (cor_rsp.done) state_in = tcc_pkg::S_SCP_GO;
         tcc_pkg::S_SCP_GO:   state_in = tcc_pkg::S_SCP;
         tcc_pkg::S_SCP:      if (cor_rsp.done) state_in = tcc_pkg::S_MUL;
         tcc_pkg::S_MUL:      if (mstep_ff == 3'd7) state_in = tcc_pkg::S_YAW_GO;
         tcc_pkg::S_YAW_GO:   state_in = yaw_zero ? tcc_pkg::S_DONE : tcc_pkg::S_YAW;
         tcc_pkg::S_YAW:      if (cor_rsp.done) state_in = tcc_pkg::S_DONE;
         tcc_pkg::S_DONE:     if (out_free) state_in = tcc_pkg::S_IDLE;
         default:             state_in = tcc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcc_pkg::S_IDLE;
         gravity_ff    <= 15'd4096;
         last_roll_ff  <= '0;
         last_pitch_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         mstep_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) begin
            gravity_ff <= csr_bus.gravity_counts;
         end
         if ((state_ff == tcc_pkg::S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            tcc_pkg::S_ROLL:
               if (cor_rsp.done && (abs_ax > 17'(gravity_ff))) begin
                  last_roll_ff  <= 16'(16'd0 - cor_rsp.angle);
                  last_pitch_ff <= ax_ff[15] ? 16'(-tcc_pkg::QuarterTurn) :
                                   16'(tcc_pkg::QuarterTurn);
               end
            tcc_pkg::S_PITCH_GO:
               if (pitch_zero) begin
                  last_roll_ff  <= roll_ff;
                  last_pitch_ff <= '0;
               end
            tcc_pkg::S_PITCH:
               if (cor_rsp.done) begin
                  last_roll_ff  <= roll_ff;
                  last_pitch_ff <= cor_rsp.angle;
               end
            tcc_pkg::S_MUL:
               mstep_ff <= mstep_ff + 1'b1;
            default: begin
               mstep_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      unique case (state_ff)
         tcc_pkg::S_IDLE:
            if (req_bus.valid) begin
               ax_ff      <= req_bus.acc_x;
               ay_ff      <= req_bus.acc_y;
               az_ff      <= req_bus.acc_z;
               mx_ff      <= req_bus.mag_x;
               my_ff      <= req_bus.mag_y;
               mz_ff      <= req_bus.mag_z;
               held_ff    <= (req_bus.acc_z == 16'sd0);
               clamped_ff <= 1'b0;
               roll_ff    <= last_roll_ff;
               pitch_ff   <= last_pitch_ff;
            end
         tcc_pkg::S_ROLL:
            if (cor_rsp.done) begin
               roll_ff <= 16'(16'd0 - cor_rsp.angle);
               if (abs_ax > 17'(gravity_ff)) begin
                  clamped_ff <= 1'b1;
                  pitch_ff   <= ax_ff[15] ? 16'(-tcc_pkg::QuarterTurn) :
                                16'(tcc_pkg::QuarterTurn);
               end
            end
         tcc_pkg::S_AA:
            gg_ff <= 30'(mul_ff);
         tcc_pkg::S_PITCH_GO:
            if (pitch_zero) begin
               pitch_ff <= '0;
            end
         tcc_pkg::S_PITCH:
            if (cor_rsp.done) begin
               pitch_ff <= cor_rsp.angle;
            end
         tcc_pkg::S_SCR:
            if (cor_rsp.done) begin
               cr_ff <= cor_rsp.cos_q30;
               sr_ff <= cor_rsp.sin_q30;
            end
         tcc_pkg::S_SCP:
            if (cor_rsp.done) begin
               cp_ff <= cor_rsp.cos_q30;
               sp_ff <= cor_rsp.sin_q30;
            end
         tcc_pkg::S_MUL:
            unique case (mstep_ff)
               3'd1: t1_ff <= tcc_pkg::TrigW'(mul_ff >>> 30);
               3'd2: t2_ff <= tcc_pkg::TrigW'(mul_ff >>> 30);
               3'd3: xh_ff <= tcc_pkg::DataW'(mul_ff);
               3'd4: xh_ff <= xh_ff + tcc_pkg::DataW'(mul_ff);
               3'd5: xh_ff <= xh_ff + tcc_pkg::DataW'(mul_ff);
               3'd6: yh_ff <= tcc_pkg::DataW'(mul_ff);
               3'd7: yh_ff <= yh_ff - tcc_pkg::DataW'(mul_ff);
               default: begin
                  t1_ff <= t1_ff;
               end
            endcase
         tcc_pkg::S_DONE:
            if (out_free) begin
               rsp_roll_ff    <= roll_ff;
               rsp_pitch_ff   <= pitch_ff;
               rsp_held_ff    <= held_ff;
               rsp_clamped_ff <= clamped_ff;
               rsp_void_ff    <= yaw_zero;
               rsp_yaw_ff     <= yaw_zero ? 16'd0 : cor_rsp.angle;
            end
         default: begin
            gg_ff <= gg_ff;
         end
      endcase
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.roll_angle    = rsp_roll_ff;
   assign rsp_bus.pitch_angle   = rsp_pitch_ff;
   assign rsp_bus.yaw_angle     = rsp_yaw_ff;
   assign rsp_bus.tilt_held     = rsp_held_ff;
   assign rsp_bus.pitch_clamped = rsp_clamped_ff;
   assign rsp_bus.heading_void  = rsp_void_ff;

endmodule

// File: hdl/tcc_checker.sv
// Port-level assertions for the compass core and the bind that attaches them.
module tcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_yaw,
   input logic        rsp_held,
   input logic        rsp_clamped,
   input logic        rsp_void
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw))
      else $error("result dropped or changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while busy");

   a_clamp_not_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |-> !rsp_held)
      else $error("clamp flag with held tilt");

   a_void_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_void |-> rsp_yaw == 16'd0)
      else $error("void heading with nonzero yaw");

endmodule

bind tilt_compensated_compass_core tcc_checker u_tcc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_yaw(rsp_bus.yaw_angle),
   .rsp_held(rsp_bus.tilt_held),
   .rsp_clamped(rsp_bus.pitch_clamped),
   .rsp_void(rsp_bus.heading_void)
);

// File: dv/tcc_tb_scoreboard.sv
// Scoreboard class: bit-exact compass predictor and queue of expected results.
package tcc_tb_scoreboard_pkg;

   localparam int NumSteps = 16;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic               held;
      logic               clamped;
      logic               hvoid;
   } heading_result_type;

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -1 - ((-1 - v) >>> s);
   endfunction

   function automatic logic [31:0] arctan_step(int i);
      logic [31:0] t [24] = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                              32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                              32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                              32'd166886, 32'd83443, 32'd41722, 32'd20861,
                              32'd10430, 32'd5215, 32'd2608, 32'd1304,
                              32'd652, 32'd326, 32'd163, 32'd81};
      return t[i];
   endfunction

   function automatic logic [15:0] vector_angle(longint y, longint x);
      logic [31:0] acc;
      longint xn, yn;
      acc = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 32'h8000_0000;
      end
      for (int i = 0; i < NumSteps; i++) begin
         if (y >= 0) begin
            xn = x + floor_shift(y, i);
            yn = y - floor_shift(x, i);
            acc = acc + arctan_step(i);
         end else begin
            xn = x - floor_shift(y, i);
            yn = y + floor_shift(x, i);
            acc = acc - arctan_step(i);
         end
         x = xn;
         y = yn;
      end
      acc = acc + 32'h8000;
      return acc[31:16];
   endfunction

   function automatic void rotate_angle(logic [15:0] a, output longint c, output longint s);
      logic [31:0] th;
      logic        flip;
      longint      x, y, z, xn, yn;
      th = {a, 16'h0};
      flip = 1'b0;
      x = 652032875;
      y = 0;
      if (th[31:30] == 2'd1 || th[31:30] == 2'd2) begin
         th = th + 32'h8000_0000;
         flip = 1'b1;
      end
      z = longint'(signed'(th));
      for (int i = 0; i < NumSteps; i++) begin
         if (z >= 0) begin
            xn = x - floor_shift(y, i);
            yn = y + floor_shift(x, i);
            z = z - longint'(arctan_step(i));
         end else begin
            xn = x + floor_shift(y, i);
            yn = y - floor_shift(x, i);
            z = z + longint'(arctan_step(i));
         end
         x = xn;
         y = yn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   class compass_scoreboard;
      logic [14:0]        gravity;
      logic [15:0]        held_roll;
      logic [15:0]        held_pitch;
      heading_result_type pending[$];
      int                 errors;

      function new();
         gravity = 15'd4096;
         held_roll = 0;
         held_pitch = 0;
         errors = 0;
      endfunction

      function void note_sample(logic signed [15:0] ax16, logic signed [15:0] ay16,
                                logic signed [15:0] az16, logic signed [15:0] mx16,
                                logic signed [15:0] my16, logic signed [15:0] mz16);
         heading_result_type r;
         longint ax, ay, az, mx, my, mz, g, aa, cr, sr, cp, sp, xh, yh;
         logic [15:0] roll, pitch, rr;
         ax = ax16; ay = ay16; az = az16; mx = mx16; my = my16; mz = mz16;
         r.held = 0;
         r.clamped = 0;
         r.hvoid = 0;
         if (az == 0) begin
            r.held = 1;
            roll = held_roll;
            pitch = held_pitch;
         end else begin
            g = gravity;
            aa = ax < 0 ? -ax : ax;
            rr = vector_angle(ay * 1048576, -az * 1048576);
            roll = 16'd0 - rr;
            if (aa > g) begin
               r.clamped = 1;
               pitch = ax > 0 ? 16'h4000 : 16'hC000;
            end else begin
               pitch = vector_angle(ax * 65536,
                                    longint'(int_root(longint'(g * g - ax * ax) << 32)));
            end
            held_roll = roll;
            held_pitch = pitch;
         end
         rotate_angle(roll, cr, sr);
         rotate_angle(pitch, cp, sp);
         xh = mx * cp + my * floor_shift(sr * sp, 30) + mz * floor_shift(cr * sp, 30);
         yh = mz * sr - my * cr;
         if (xh == 0 && yh == 0) begin
            r.hvoid = 1;
            r.yaw = 0;
         end else begin
            r.yaw = vector_angle(yh, xh);
         end
         r.roll = roll;
         r.pitch = pitch;
         pending.push_back(r);
      endfunction

      function void check_result(heading_result_type got);
         heading_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result roll=%0d", $realtime, got.roll);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.roll !== e.roll || got.pitch !== e.pitch || got.yaw !== e.yaw ||
             got.held !== e.held || got.clamped !== e.clamped || got.hvoid !== e.hvoid) begin
            $display("%0t: mismatch expected r=%0d p=%0d y=%0d h=%b c=%b v=%b", $realtime,
                     e.roll, e.pitch, e.yaw, e.held, e.clamped, e.hvoid);
            $display("%0t:          actual   r=%0d p=%0d y=%0d h=%b c=%b v=%b", $realtime,
                     got.roll, got.pitch, got.yaw, got.held, got.clamped, got.hvoid);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: dv/tb.sv
// Top-level testbench for the tilt-compensated compass core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   longint cycles = 0;
   tcc_tb_scoreboard_pkg::compass_scoreboard sb = new();

   tcc_req_if req_bus();
   tcc_rsp_if rsp_bus();
   tcc_csr_if csr_bus();

   tilt_compensated_compass_core DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      {req_bus.acc_x, req_bus.acc_y, req_bus.acc_z} = '0;
      {req_bus.mag_x, req_bus.mag_y, req_bus.mag_z} = '0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.gravity_counts = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern: phases of always-ready and random stalls
   int stall_mode = 0;
   always @(posedge clock) begin
      tcc_tb_scoreboard_pkg::heading_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.roll = rsp_bus.roll_angle;
         got.pitch = rsp_bus.pitch_angle;
         got.yaw = rsp_bus.yaw_angle;
         got.held = rsp_bus.tilt_held;
         got.clamped = rsp_bus.pitch_clamped;
         got.hvoid = rsp_bus.heading_void;
         sb.check_result(got);
      end
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   int gap_left = 0;
   int burst_left = 0;

   task automatic send_sample(logic signed [15:0] ax, ay, az, mx, my, mz);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
         if (gap_left > 0) begin
            req_bus.valid <= 0;
            repeat (gap_left) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1;
      req_bus.acc_x <= ax; req_bus.acc_y <= ay; req_bus.acc_z <= az;
      req_bus.mag_x <= mx; req_bus.mag_y <= my; req_bus.mag_z <= mz;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_sample(ax, ay, az, mx, my, mz);
   endtask

   task automatic write_gravity(logic [14:0] g);
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_bus.valid <= 1;
      csr_bus.gravity_counts <= g;
      do @(posedge clock); while (!csr_bus.ready);
      sb.gravity = g;
      csr_bus.valid <= 0;
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(int n, logic [14:0] g);
      logic signed [15:0] ax;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) != 0)
            ax = 16'($urandom_range(0, 2 * g)) - 16'(g);
         else
            ax = rand_field();
         send_sample(ax, rand_field(), $urandom_range(0, 9) == 0 ? 16'sd0 : rand_field(),
                     rand_field(), rand_field(), rand_field());
      end
   endtask

   initial begin
      logic [14:0] g_set [6] = '{15'd4096, 15'd1, 15'd32767, 15'd0, 15'd1000, 15'd16384};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: held state from reset, extremes, pi angles, clamping, void heading
      send_sample(0, 0, 0, 100, 200, 300);
      send_sample(0, 0, 0, 0, 0, 0);
      send_sample(0, 0, 4096, 0, 0, 0);
      send_sample(0, 0, -4096, 1000, 0, 0);
      send_sample(0, 0, 4096, -1000, 0, 0);
      send_sample(4096, 0, 4096, 500, 500, 500);
      send_sample(-4096, 0, 4096, 500, -500, 500);
      send_sample(4097, 100, 4096, 1, 2, 3);
      send_sample(-4097, -100, 4096, 1, 2, 3);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768);
      send_sample(32767, 32767, 32767, 32767, 32767, 32767);
      send_sample(0, 32767, 0, 7, 8, 9);
      send_sample(0, -32768, 1, 7, -8, 9);
      send_sample(2000, 3000, -1, 32767, -32768, 0);
      send_sample(0, 0, 0, 0, 0, 0);
      write_gravity(15'd0);
      send_sample(0, 5, 5, 5, 5, 5);
      send_sample(1, 5, 5, 5, 5, 5);
      send_sample(-1, 5, 5, 5, 5, 5);
      random_phase(20, 15'd0);
      for (int p = 0; p < 6; p++) begin
         write_gravity(g_set[p]);
         random_phase(280, g_set[p]);
      end
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
